[rtl/tdpt_pkg.sv]
// package for the trial-division prime test
// holds the value width, trial-divisor constants, handshake structs and fsm states
// no dependencies
package tdpt_pkg;

    localparam int VALUE_BITS = 30;
    localparam int REM_W      = VALUE_BITS + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    // divisor walk 5, 11, 17, ... with the square kept by running sums
    localparam int FIRST_DIV  = 5;
    localparam int DIV_STEP   = 6;
    localparam int PAIR_GAP   = 2;
    localparam int SMALL_DIV  = 3;
    localparam int FIRST_SQ   = FIRST_DIV * FIRST_DIV;
    localparam int FIRST_INC  = 2 * DIV_STEP * FIRST_DIV + DIV_STEP * DIV_STEP;
    localparam int INC_STEP   = 2 * DIV_STEP * DIV_STEP;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [REM_W-1:0]      t_wide;

    typedef struct packed {
        logic   start;
        t_value divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctl;

    typedef struct packed {
        t_value divisor;
        t_wide  square;
    } t_step_val;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_MOD3,
        ST_BOUND,
        ST_MODD,
        ST_MODD2,
        ST_RESULT
    } t_state;

endpackage

[rtl/tdpt_rem.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on tdpt_pkg
module tdpt_rem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdpt_pkg::t_rem_req i_req,
    input  tdpt_pkg::t_value   i_dividend,
    output tdpt_pkg::t_rem_rsp o_rsp
);

    tdpt_pkg::t_wide              r_rem;
    tdpt_pkg::t_value             r_num;
    tdpt_pkg::t_value             r_div;
    logic [tdpt_pkg::CNT_W-1:0]   r_count;
    logic                         r_busy;
    logic                         r_done;

    tdpt_pkg::t_wide w_trial;
    tdpt_pkg::t_wide w_diff;
    tdpt_pkg::t_wide n_rem;

    always_comb begin
        w_trial = {r_rem[tdpt_pkg::VALUE_BITS-1:0], r_num[tdpt_pkg::VALUE_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = (w_trial >= {1'b0, r_div}) ? w_diff : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= tdpt_pkg::CNT_W'(tdpt_pkg::VALUE_BITS - 1);
                r_rem   <= '0;
                r_num   <= i_dividend;
                r_div   <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[tdpt_pkg::VALUE_BITS-2:0], 1'b0};
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

[rtl/tdpt_step.sv]
// trial divisor stepper: divisor and its square, updated by additions only
// depends on tdpt_pkg
module tdpt_step (
    input  logic                i_clk,
    input  tdpt_pkg::t_step_ctl i_ctl,
    output tdpt_pkg::t_step_val o_val
);

    tdpt_pkg::t_value r_div;
    tdpt_pkg::t_wide  r_sq;
    tdpt_pkg::t_wide  r_inc;

    // (d+6)^2 = d^2 + (12d + 36), and the increment grows by 72 per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_div <= tdpt_pkg::VALUE_BITS'(tdpt_pkg::FIRST_DIV);
            r_sq  <= tdpt_pkg::REM_W'(tdpt_pkg::FIRST_SQ);
            r_inc <= tdpt_pkg::REM_W'(tdpt_pkg::FIRST_INC);
        end else if (i_ctl.advance) begin
            r_div <= r_div + tdpt_pkg::VALUE_BITS'(tdpt_pkg::DIV_STEP);
            r_sq  <= r_sq + r_inc;
            r_inc <= r_inc + tdpt_pkg::REM_W'(tdpt_pkg::INC_STEP);
        end
    end

    assign o_val.divisor = r_div;
    assign o_val.square  = r_sq;

endmodule

[rtl/trial_division_prime_test.sv]
// top level of the trial-division prime test: handshakes, sequencer, result register
// depends on tdpt_pkg, tdpt_rem and tdpt_step
//
// Tests one unsigned candidate of tdpt_pkg::VALUE_BITS bits per transfer and returns
// one flag, 1 when the candidate is prime. Values below 2 give 0, 2 and 3 give 1, even
// values give 0. Otherwise the candidate is checked against 3 and then against the
// divisor pairs d and d+2 for d = 5, 11, 17, ... while d*d does not exceed it. Each
// trial is a bit-serial remainder, and every divisor pair adds a bound check, so one
// item runs through the screen and the check against 3 and then through each divisor
// pair tried, about sqrt(n)/6 pairs for a prime. The worst case at 30 bits is the
// largest prime, which takes the full divisor walk. Early exit on the first divisor
// found makes composites much quicker. One item is in work at a time: a new
// candidate transfer is taken whenever the sequencer is idle, even while the previous
// result still waits in the output register.
module trial_division_prime_test (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tdpt_pkg::t_value i_candidate,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_is_prime
);

    tdpt_pkg::t_state    r_state;
    tdpt_pkg::t_state    n_state;
    tdpt_pkg::t_value    r_cand;
    logic                r_prime;
    logic                n_prime;
    logic                r_out_valid;
    logic                r_out_prime;

    tdpt_pkg::t_rem_req  w_req;
    tdpt_pkg::t_rem_rsp  w_rsp;
    tdpt_pkg::t_step_ctl w_ctl;
    tdpt_pkg::t_step_val w_val;

    logic w_in_xfer;
    logic w_out_free;

    assign o_in_ready  = (r_state == tdpt_pkg::ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

    // shared serial remainder unit, dividend is always the held candidate
    tdpt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (r_cand),
        .o_rsp      (w_rsp)
    );

    // divisor walk with running square for the loop bound
    tdpt_step u_step (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_val (w_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tdpt_pkg::ST_RESULT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cand <= i_candidate;
        end
        r_prime <= n_prime;
        if (r_state == tdpt_pkg::ST_RESULT && w_out_free) begin
            r_out_prime <= r_prime;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_prime       = r_prime;
        w_req.start   = 1'b0;
        w_req.divisor = w_val.divisor;
        w_ctl.load    = 1'b0;
        w_ctl.advance = 1'b0;

        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = tdpt_pkg::ST_SCREEN;
                end
            end
            // small values and even values settle at once
            tdpt_pkg::ST_SCREEN: begin
                if (r_cand < tdpt_pkg::VALUE_BITS'(2)) begin
                    n_prime = 1'b0;
                    n_state = tdpt_pkg::ST_RESULT;
                end else if (r_cand <= tdpt_pkg::VALUE_BITS'(tdpt_pkg::SMALL_DIV)) begin
                    n_prime = 1'b1;
                    n_state = tdpt_pkg::ST_RESULT;
                end else if (!r_cand[0]) begin
                    n_prime = 1'b0;
                    n_state = tdpt_pkg::ST_RESULT;
                end else begin
                    w_req.start   = 1'b1;
                    w_req.divisor = tdpt_pkg::VALUE_BITS'(tdpt_pkg::SMALL_DIV);
                    n_state       = tdpt_pkg::ST_MOD3;
                end
            end
            tdpt_pkg::ST_MOD3: begin
                if (w_rsp.done) begin
                    if (w_rsp.zero) begin
                        n_prime = 1'b0;
                        n_state = tdpt_pkg::ST_RESULT;
                    end else begin
                        w_ctl.load = 1'b1;
                        n_state    = tdpt_pkg::ST_BOUND;
                    end
                end
            end
            // stop once d*d passes the candidate
            tdpt_pkg::ST_BOUND: begin
                if (w_val.square > {1'b0, r_cand}) begin
                    n_prime = 1'b1;
                    n_state = tdpt_pkg::ST_RESULT;
                end else begin
                    w_req.start   = 1'b1;
                    w_req.divisor = w_val.divisor;
                    n_state       = tdpt_pkg::ST_MODD;
                end
            end
            tdpt_pkg::ST_MODD: begin
                if (w_rsp.done) begin
                    if (w_rsp.zero) begin
                        n_prime = 1'b0;
                        n_state = tdpt_pkg::ST_RESULT;
                    end else begin
                        w_req.start   = 1'b1;
                        w_req.divisor = w_val.divisor
                                      + tdpt_pkg::VALUE_BITS'(tdpt_pkg::PAIR_GAP);
                        n_state       = tdpt_pkg::ST_MODD2;
                    end
                end
            end
            tdpt_pkg::ST_MODD2: begin
                if (w_rsp.done) begin
                    if (w_rsp.zero) begin
                        n_prime = 1'b0;
                        n_state = tdpt_pkg::ST_RESULT;
                    end else begin
                        w_ctl.advance = 1'b1;
                        n_state       = tdpt_pkg::ST_BOUND;
                    end
                end
            end
            // hold the flag until the output register is free
            tdpt_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sim/trial_division_prime_test_test.sv]
// self-checking testbench for trial_division_prime_test
// depends on tdpt_pkg and the trial_division_prime_test rtl; needs no files or arguments
// directed boundary candidates, then random streams with and without idling, checked by an in-bench predictor
module trial_division_prime_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    // a 30-bit prime takes the longest in the remainder unit, and the receiver drops
    // ready only at random, so no correct run goes anywhere near this limit without
    // a single transfer on either side
    localparam int unsigned STALL_LIMIT  = 2_000_000;
    // wide random candidates whose trial walk tries more divisor pairs than this are
    // redrawn, so that they stay cheap
    localparam int unsigned WIDE_LOOP_CAP = 200;
    localparam int          FLUSH_CYCLES  = 20;
    localparam int          IDLE_PERCENT  = 6;

    typedef struct {
        tdpt_pkg::t_value candidate;
        logic             is_prime;
    } t_verdict;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    tdpt_pkg::t_value i_candidate;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_is_prime;

    t_verdict    expected_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    // when set, neither side idles: back-to-back transfers
    bit          steady         = 1'b0;

    trial_division_prime_test uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_candidate (i_candidate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_is_prime  (o_is_prime)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // 6k +/- 1 trial division; loops counts the divisor pairs tried, which is what
    // sets the block's run time for this candidate
    function automatic logic predict_prime(input tdpt_pkg::t_value n,
                                           output int unsigned loops);
        longint unsigned v;
        longint unsigned d;
        loops = 0;
        v = n;
        if (v < 2) return 1'b0;
        if (v <= tdpt_pkg::SMALL_DIV) return 1'b1;
        if (v % 2 == 0 || v % tdpt_pkg::SMALL_DIV == 0) return 1'b0;
        // d <= v/d stands for d*d <= v
        for (d = tdpt_pkg::FIRST_DIV; d <= v / d; d += tdpt_pkg::DIV_STEP) begin
            loops++;
            if (v % d == 0 || v % (d + tdpt_pkg::PAIR_GAP) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // one candidate transfer; valid is left high on return so that the next call can
    // follow straight on, or lower it when it idles
    task automatic offer_candidate(input tdpt_pkg::t_value value);
        t_verdict    item;
        int unsigned loops;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_candidate <= value;
        do @(posedge i_clk); while (!o_in_ready);
        item.candidate = value;
        item.is_prime  = predict_prime(value, loops);
        expected_verdicts.push_back(item);
    endtask

    // sender holds off until every outstanding verdict has been returned
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // boundaries of the value range and each branch of the test
    task automatic test_directed_values();
        int unsigned picks[$];
        picks = '{
            0, 1,                   // below two: not prime
            2, 3,                   // the two small primes
            4, 6, 9, 15,            // multiples of two or three
            5, 7, 11, 13,           // primes below the first trial square
            25, 35,                 // divisor d at the bound and below it
            49, 77,                 // divisor d+2 at the bound and below it
            121, 143, 169, 289, 323,
            1042441,                // square of a prime, caught by d+2 on the last pair
            32'h3FFF_FFFF,          // all ones, a multiple of three
            32'h2000_0000,          // top bit alone, even
            1073741789              // largest 30-bit prime: the full divisor walk
        };
        foreach (picks[k]) offer_candidate(tdpt_pkg::t_value'(picks[k]));
        drain_verdicts();
    endtask

    // small candidates, where primes are dense and the walk is short
    task automatic test_random_small(input int count);
        tdpt_pkg::t_value value;
        repeat (count) begin
            if ($urandom_range(0, 9) < 4) value = tdpt_pkg::t_value'($urandom_range(0, 63));
            else                          value = tdpt_pkg::t_value'($urandom_range(0, 4095));
            offer_candidate(value);
        end
        drain_verdicts();
    endtask

    // mid-range candidates up to 20 bits, every one kept
    task automatic test_random_mid(input int count);
        repeat (count) offer_candidate(tdpt_pkg::t_value'($urandom_range(0, (1 << 20) - 1)));
        drain_verdicts();
    endtask

    // full-width candidates with every bit random; those with a long walk are redrawn
    task automatic test_random_wide(input int count);
        logic [31:0]      raw;
        tdpt_pkg::t_value value;
        int unsigned      loops;
        repeat (count) begin
            do begin
                raw   = $urandom;
                value = raw[tdpt_pkg::VALUE_BITS-1:0];
                void'(predict_prime(value, loops));
            end while (loops > WIDE_LOOP_CAP);
            offer_candidate(value);
        end
        drain_verdicts();
    endtask

    // back-to-back stream with no idling on either side
    task automatic test_steady_stream(input int count);
        steady = 1'b1;
        repeat (count) offer_candidate(tdpt_pkg::t_value'($urandom_range(0, (1 << 16) - 1)));
        drain_verdicts();
        steady = 1'b0;
    endtask

    // receiver side: ready drops at random unless the steady stretch is on
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // every verdict transfer is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual is_prime=%0b",
                         $time, o_is_prime);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_is_prime !== want.is_prime) begin
                    $display("%0t: candidate %0d expected is_prime=%0b actual is_prime=%0b",
                             $time, want.candidate, want.is_prime, o_is_prime);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("trial_division_prime_test: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_candidate <= '0;
        i_out_ready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        test_random_small(30);
        test_random_mid(15);
        test_random_wide(20);
        test_steady_stream(10);

        // nothing is left outstanding; keep clocking to catch a stray verdict
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("trial_division_prime_test: match");
        end else begin
            $display("trial_division_prime_test: mismatch");
        end
        $finish;
    end

endmodule
